// ----- src/byte_stream_shellcode_scanner_macros.svh -----
// Assertion macros shared by the scanner checker.
// Needs nothing else; included by the checker file by its bare name.
`ifndef BYTE_STREAM_SHELLCODE_SCANNER_MACROS_SVH
`define BYTE_STREAM_SHELLCODE_SCANNER_MACROS_SVH

// Same-cycle implication, dropped while reset is asserted.
`define BSSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, dropped while reset is asserted.
`define BSSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bssc_pkg.sv -----
// Shared types, constants and match helpers of the byte-stream shellcode scanner.
// Depends on nothing; used by every RTL module of the block.
package bssc_pkg;

    localparam int unsigned COUNT_BITS_DEF = 20;
    localparam int unsigned OUT_COUNT_W    = 20;
    localparam int unsigned FRAC_BITS      = 16;
    localparam int unsigned DENS_W         = FRAC_BITS + 1;
    localparam int unsigned WIN_DEPTH      = 27;
    localparam int unsigned WIN_BYTES      = WIN_DEPTH + 1;
    localparam int unsigned WIN_W          = 8 * WIN_BYTES;
    localparam int unsigned NUM_PATTERNS   = 8;
    localparam int unsigned NUM_FLAGS      = 6;
    localparam int unsigned FOUND_W        = NUM_PATTERNS + 2;
    localparam int unsigned OUT_TDATA_W    = 64;

    // sticky match bits
    localparam int unsigned BIT_GPA   = 0;
    localparam int unsigned BIT_GPW   = 1;
    localparam int unsigned BIT_LDR   = 2;
    localparam int unsigned BIT_K32   = 3;
    localparam int unsigned BIT_EGG   = 4;
    localparam int unsigned BIT_VA    = 5;
    localparam int unsigned BIT_WPM   = 6;
    localparam int unsigned BIT_CRT   = 7;
    localparam int unsigned BIT_PIVOT = 8;
    localparam int unsigned BIT_NOP   = 9;

    // configuration register indexes
    localparam logic CFG_MIN_SCAN  = 1'b0;
    localparam logic CFG_SLED_LEN  = 1'b1;

    localparam logic [7:0] RST_MIN_SCAN = 8'd16;
    localparam logic [7:0] RST_SLED_LEN = 8'd16;

    localparam logic [7:0] BYTE_NOP       = 8'h90;
    localparam logic [7:0] BYTE_XCHG      = 8'h94;
    localparam logic [7:0] BYTE_MOV       = 8'h89;
    localparam logic [7:0] PIVOT_MASK     = 8'hF8;
    localparam logic [7:0] PIVOT_REG_BASE = 8'hE0;

    // Patterns sit with their final character in the low byte, so byte k of
    // the constant lines up with the byte k positions before the current one.
    localparam logic [WIN_W-1:0] PAT_GPA = {{(WIN_W - 8*14){1'b0}}, "GetProcAddress"};
    localparam logic [WIN_W-1:0] PAT_LDR = {{(WIN_W - 8*3){1'b0}}, "Ldr"};
    localparam logic [WIN_W-1:0] PAT_K32 = {{(WIN_W - 8*12){1'b0}}, "kernel32.dll"};
    localparam logic [WIN_W-1:0] PAT_EGG = {{(WIN_W - 32){1'b0}}, 32'h6681_3C33};
    localparam logic [WIN_W-1:0] PAT_VA  = {{(WIN_W - 8*12){1'b0}}, "VirtualAlloc"};
    localparam logic [WIN_W-1:0] PAT_WPM = {{(WIN_W - 8*18){1'b0}}, "WriteProcessMemory"};
    localparam logic [WIN_W-1:0] PAT_CRT = {{(WIN_W - 8*18){1'b0}}, "CreateRemoteThread"};

    localparam logic [4:0] LEN_GPA = 5'd14;
    localparam logic [4:0] LEN_GPW = 5'd28;
    localparam logic [4:0] LEN_LDR = 5'd3;
    localparam logic [4:0] LEN_K32 = 5'd12;
    localparam logic [4:0] LEN_EGG = 5'd4;
    localparam logic [4:0] LEN_VA  = 5'd12;
    localparam logic [4:0] LEN_WPM = 5'd18;
    localparam logic [4:0] LEN_CRT = 5'd18;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } t_win_tap;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // 16-bit-character form: every character followed by a zero byte
    function automatic logic [WIN_W-1:0] wide_form(input logic [WIN_W-1:0] narrow);
        logic [WIN_W-1:0] r;
        r = '0;
        for (int k = 0; k < WIN_BYTES / 2; k++) begin
            r[16*k+8 +: 8] = narrow[8*k +: 8];
        end
        return r;
    endfunction

    localparam logic [WIN_W-1:0] PAT_GPW = wide_form(PAT_GPA);

    function automatic logic pat_hit(input logic [WIN_W-1:0] win,
                                     input logic [WIN_BYTES-1:0] avail,
                                     input logic [WIN_W-1:0] pat,
                                     input logic [4:0] len);
        logic hit;
        hit = avail[len - 5'd1];
        for (int k = 0; k < WIN_BYTES; k++) begin
            if ((k < int'(len)) && (win[8*k +: 8] != pat[8*k +: 8])) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic logic is_opcode(input logic [7:0] b);
        logic r;
        case (b)
            8'h55, 8'h53, 8'h57, 8'h56, 8'h48, 8'h8B, 8'h89, 8'hE8,
            8'hE9, 8'hFF, 8'h41, 8'h40, 8'hB8, 8'hB9, 8'hBA, 8'hEB: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/bssc_cell.sv -----
// One byte cell of the scan window: holds a byte and its valid bit.
// Depends on bssc_pkg; chained by the top level into the window.
module bssc_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic                i_clear,
    input  bssc_pkg::t_win_tap  i_tap,
    output bssc_pkg::t_win_tap  o_tap
);
    import bssc_pkg::*;

    logic       r_vld;
    logic [7:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_shift) begin
            r_vld <= i_tap.vld & ~i_clear;
        end
    end

    // payload needs no reset: valid bit qualifies it
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_tap.data;
        end
    end

    assign o_tap = '{vld: r_vld, data: r_data};

endmodule

// ----- src/bssc_div.sv -----
// Bit-serial restoring divider for the opcode density, one quotient bit a cycle.
// Depends on bssc_pkg; quotient = floor(num * 2^16 / den) for num <= den.
module bssc_div #(
    parameter int unsigned COUNT_BITS = bssc_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [COUNT_BITS-1:0]         i_num,
    input  logic [COUNT_BITS-1:0]         i_den,
    input  logic                          i_ack,
    output bssc_pkg::t_div_stat           o_stat,
    output logic [bssc_pkg::DENS_W-1:0]   o_quot
);
    import bssc_pkg::*;

    localparam int unsigned STEP_W = $clog2(FRAC_BITS);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_den;
    logic [DENS_W-1:0]     r_quot;

    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  ge;

    assign trial = {r_rem, 1'b0};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(FRAC_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (i_ack) begin
            r_done <= 1'b0;
        end
    end

    // integer bit on load, then one fraction bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            if (i_num >= i_den) begin
                r_rem  <= i_num - i_den;
                r_quot <= DENS_W'(1);
            end else begin
                r_rem  <= i_num;
                r_quot <= '0;
            end
        end else if (r_busy) begin
            r_rem  <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            r_quot <= {r_quot[DENS_W-2:0], ge};
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quot = r_quot;

endmodule

// ----- src/byte_stream_shellcode_scanner.sv -----
// Top level of the byte-stream shellcode scanner: window cells, matchers, counters.
// Depends on bssc_pkg, bssc_cell and bssc_div.
//
//  channel  | dir | beat holds
//  ---------+-----+----------------------------------------------------------
//  s_axis   | in  | one buffer byte (tdata), final byte of buffer (tlast)
//  m_axis   | out | one verdict per buffer, packed flags, counts and density
//  i_cfg_*  | in  | register write: 0 = min_scan_size, 1 = nop_sled_length
//
// Flow: one byte a cycle while a buffer streams in. The final byte loads the
// divider, which then works out the density; input stalls from then until the
// verdict moves into the output register, which may then wait on m_axis_tready.
// Reset (synchronous, active low) clears the window, counters and handshakes
// and loads 16 into both configuration registers.
module byte_stream_shellcode_scanner #(
    parameter int unsigned COUNT_BITS = bssc_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    // byte input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // verdict output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] has_getproc, [1] has_loader_walk, [2] has_stack_pivot, [3] has_nop_sled,
    // [4] has_egg_hunter, [5] has_api_sequence, [25:6] byte_count,
    // [45:26] opcode_count, [62:46] density_q16, [63] zero
    output logic [63:0] m_axis_tdata
);
    import bssc_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration
    logic [7:0] r_min_scan;
    logic [7:0] r_sled_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_scan <= RST_MIN_SCAN;
            r_sled_len <= RST_SLED_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_SCAN: r_min_scan <= i_cfg_wdata;
                CFG_SLED_LEN: r_sled_len <= i_cfg_wdata;
                default:      r_min_scan <= r_min_scan;
            endcase
        end
    end

    logic      s_acc;
    logic      s_end;
    t_div_stat div_stat;
    logic [DENS_W-1:0] div_quot;

    // stall input while the divider holds a verdict
    assign s_axis_tready = ~div_stat.busy & ~div_stat.done;
    assign s_acc = s_axis_tvalid & s_axis_tready;
    assign s_end = s_acc & s_axis_tlast;

    // window: a chain of byte cells, newest byte enters cell 0
    t_win_tap tap [WIN_DEPTH];

    for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
        t_win_tap cell_in;
        if (k == 0) begin : g_head
            assign cell_in = '{vld: 1'b1, data: s_axis_tdata};
        end else begin : g_body
            assign cell_in = tap[k-1];
        end
        bssc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (s_acc),
            .i_clear (s_axis_tlast),
            .i_tap   (cell_in),
            .o_tap   (tap[k])
        );
    end

    // current byte plus window, flattened for the pattern compares
    logic [WIN_W-1:0]     win;
    logic [WIN_BYTES-1:0] avail;

    always_comb begin
        win[7:0] = s_axis_tdata;
        avail[0] = 1'b1;
        for (int k = 1; k < WIN_BYTES; k++) begin
            win[8*k +: 8] = tap[k-1].data;
            avail[k]      = tap[k-1].vld;
        end
    end

    logic [NUM_PATTERNS-1:0] hit;

    assign hit[BIT_GPA] = pat_hit(win, avail, PAT_GPA, LEN_GPA);
    assign hit[BIT_GPW] = pat_hit(win, avail, PAT_GPW, LEN_GPW);
    assign hit[BIT_LDR] = pat_hit(win, avail, PAT_LDR, LEN_LDR);
    assign hit[BIT_K32] = pat_hit(win, avail, PAT_K32, LEN_K32);
    assign hit[BIT_EGG] = pat_hit(win, avail, PAT_EGG, LEN_EGG);
    assign hit[BIT_VA]  = pat_hit(win, avail, PAT_VA,  LEN_VA);
    assign hit[BIT_WPM] = pat_hit(win, avail, PAT_WPM, LEN_WPM);
    assign hit[BIT_CRT] = pat_hit(win, avail, PAT_CRT, LEN_CRT);

    // stack pivot: previous byte 0x94, or 0x89 then a register in E0..E7
    logic pivot_hit;
    assign pivot_hit = tap[0].vld &
        ((tap[0].data == BYTE_XCHG) |
         ((tap[0].data == BYTE_MOV) & ((s_axis_tdata & PIVOT_MASK) == PIVOT_REG_BASE)));

    // NOP run, saturating at 255; a zero length acts as one
    logic [7:0] r_nop_run;
    logic [7:0] n_nop_run;
    logic [7:0] sled_need;
    logic       is_nop;
    logic       nop_hit;

    assign is_nop    = (s_axis_tdata == BYTE_NOP);
    assign sled_need = (r_sled_len == 8'd0) ? 8'd1 : r_sled_len;
    assign n_nop_run = !is_nop ? 8'd0 : ((r_nop_run == 8'hFF) ? r_nop_run : r_nop_run + 8'd1);
    assign nop_hit   = is_nop & (n_nop_run >= sled_need);

    // sticky match bits
    logic [FOUND_W-1:0] r_found;
    logic [FOUND_W-1:0] n_found;

    assign n_found = r_found | {nop_hit, pivot_hit, hit};

    // saturating counters
    logic [COUNT_BITS-1:0] r_len;
    logic [COUNT_BITS-1:0] n_len;
    logic [COUNT_BITS-1:0] r_ops;
    logic [COUNT_BITS-1:0] n_ops;

    assign n_len = (r_len == COUNT_MAX) ? r_len : r_len + 1'b1;
    assign n_ops = (is_opcode(s_axis_tdata) && (r_ops != COUNT_MAX)) ? r_ops + 1'b1 : r_ops;

    // advance scan state on every byte, drop it after the final one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found   <= '0;
            r_nop_run <= '0;
            r_len     <= '0;
            r_ops     <= '0;
        end else if (s_acc) begin
            if (s_axis_tlast) begin
                r_found   <= '0;
                r_nop_run <= '0;
                r_len     <= '0;
                r_ops     <= '0;
            end else begin
                r_found   <= n_found;
                r_nop_run <= n_nop_run;
                r_len     <= n_len;
                r_ops     <= n_ops;
            end
        end
    end

    // verdict of the finishing buffer
    logic                 long_enough;
    logic [FOUND_W-1:0]   f;
    logic [NUM_FLAGS-1:0] flags;

    assign long_enough = (n_len >= COUNT_BITS'(r_min_scan));
    assign f = long_enough ? n_found : '0;
    assign flags = {
        f[BIT_VA] & f[BIT_WPM] & f[BIT_CRT],
        f[BIT_EGG],
        f[BIT_NOP],
        f[BIT_PIVOT],
        f[BIT_LDR] & f[BIT_K32],
        f[BIT_GPA] | f[BIT_GPW]
    };

    // hold flags and counts while the divider works
    logic [NUM_FLAGS-1:0]   r_pend_flags;
    logic [OUT_COUNT_W-1:0] r_pend_len;
    logic [OUT_COUNT_W-1:0] r_pend_ops;

    always_ff @(posedge i_clk) begin
        if (s_end) begin
            r_pend_flags <= flags;
            r_pend_len   <= OUT_COUNT_W'(n_len);
            r_pend_ops   <= OUT_COUNT_W'(n_ops);
        end
    end

    logic div_take;

    bssc_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_end),
        .i_num   (n_ops),
        .i_den   (n_len),
        .i_ack   (div_take),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // output register: refill when empty or when its beat leaves
    logic                   r_out_vld;
    logic [NUM_FLAGS-1:0]   r_out_flags;
    logic [OUT_COUNT_W-1:0] r_out_len;
    logic [OUT_COUNT_W-1:0] r_out_ops;
    logic [DENS_W-1:0]      r_out_dens;

    assign div_take = div_stat.done & (~r_out_vld | m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (div_take) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_take) begin
            r_out_flags <= r_pend_flags;
            r_out_len   <= r_pend_len;
            r_out_ops   <= r_pend_ops;
            r_out_dens  <= div_quot;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_dens, r_out_ops, r_out_len, r_out_flags};

endmodule

// ----- src/bssc_chk.sv -----
// Port-level checker for the byte-stream shellcode scanner, bound to the top level.
// Depends on byte_stream_shellcode_scanner_macros.svh.
`include "byte_stream_shellcode_scanner_macros.svh"

module bssc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // a stalled verdict beat holds
    `BSSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "verdict changed while stalled")

    // the divider runs after a final byte, so input stalls
    `BSSC_ASSERT_NEXT(a_stall_after_end, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready,
        "input accepted right after a final byte")

    // density never exceeds one and a buffer has at least one byte
    `BSSC_ASSERT_NOW(a_dens_range, i_clk, i_rst_n, m_axis_tvalid,
        (m_axis_tdata[62:46] <= 17'h10000) && (m_axis_tdata[25:6] != 20'd0),
        "density above one or empty buffer reported")

    // pad bit stays clear
    `BSSC_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[63] == 1'b0, "verdict pad bit set")

endmodule

bind byte_stream_shellcode_scanner bssc_chk u_bssc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- dv/byte_stream_shellcode_scanner_tb.sv -----
// Self-checking testbench for byte_stream_shellcode_scanner: streams buffers of bytes,
// predicts each verdict in a scoreboard class and compares it field by field.
// Depends on bssc_pkg and the scanner RTL only.
module byte_stream_shellcode_scanner_tb;

    import bssc_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int TIMEOUT_CYCLES  = 500_000;
    localparam int SETTLE_CYCLES   = 40;    // divider plus output register, with margin
    localparam int DRAIN_CYCLES    = 60;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_BYTES    = 1150;
    localparam int PHASE_BYTES     = 150;
    localparam int NUM_TABLED      = 8;

    // Verdict layout on m_axis_tdata, top field first.
    typedef struct packed {
        logic        pad;
        logic [16:0] density_q16;
        logic [19:0] opcode_count;
        logic [19:0] byte_count;
        logic        has_api_sequence;
        logic        has_egg_hunter;
        logic        has_nop_sled;
        logic        has_stack_pivot;
        logic        has_loader_walk;
        logic        has_getproc;
    } verdict_t;

    // Predicts the verdict of every buffer from the beats that went in and
    // checks the beats that come out against the oldest prediction.
    class verdict_scoreboard;
        localparam logic [19:0] COUNT_MAX = 20'hFFFFF;

        logic [7:0]  sig_bytes[8][$];   // search strings, indexed by match bit
        logic [7:0]  opcode_set[16] = '{8'h55, 8'h53, 8'h57, 8'h56, 8'h48, 8'h8B, 8'h89,
                                        8'hE8, 8'hE9, 8'hFF, 8'h41, 8'h40, 8'hB8, 8'hB9,
                                        8'hBA, 8'hEB};
        logic [7:0]  min_scan;
        logic [7:0]  sled_len;
        logic [7:0]  hist[27];          // hist[0] is the byte just before the current one
        int          fill;
        logic [9:0]  found;
        int          nop_run;
        logic [19:0] len_cnt;
        logic [19:0] op_cnt;
        verdict_t    expected_verdicts[$];
        int          mismatches;
        int          bytes_seen;
        int          buffers_seen;
        int          short_buffers;
        int          flag_hits[6];

        function new();
            string txt[8];
            txt = '{"GetProcAddress", "", "Ldr", "kernel32.dll", "", "VirtualAlloc",
                    "WriteProcessMemory", "CreateRemoteThread"};
            for (int i = 0; i < 8; i++) begin
                for (int c = 0; c < txt[i].len(); c++) begin
                    sig_bytes[i].push_back(txt[i][c]);
                end
            end
            // wide-character form: each character followed by a zero byte
            for (int c = 0; c < txt[BIT_GPA].len(); c++) begin
                sig_bytes[BIT_GPW].push_back(txt[BIT_GPA][c]);
                sig_bytes[BIT_GPW].push_back(8'h00);
            end
            sig_bytes[BIT_EGG] = '{8'h66, 8'h81, 8'h3C, 8'h33};
            min_scan = RST_MIN_SCAN;
            sled_len = RST_SLED_LEN;
            clear_scan();
        endfunction

        function void clear_scan();
            foreach (hist[k]) hist[k] = 8'h00;
            fill    = 0;
            found   = '0;
            nop_run = 0;
            len_cnt = '0;
            op_cnt  = '0;
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        function bit is_opcode_byte(logic [7:0] b);
            foreach (opcode_set[i]) begin
                if (opcode_set[i] == b) return 1'b1;
            end
            return 1'b0;
        endfunction

        // Advance the scan state by one accepted byte beat.
        function void note_byte(logic [7:0] b, logic last);
            logic [7:0]  w[28];
            int          n;
            int          need;
            bit          hit;
            bit          ok;
            logic [35:0] num;
            logic [35:0] quo;
            verdict_t    v;
            w[0] = b;
            for (int k = 1; k < 28; k++) w[k] = hist[k-1];
            // a string matches when it ends on the current byte
            for (int i = 0; i < 8; i++) begin
                n = sig_bytes[i].size();
                if (n <= fill + 1) begin
                    hit = 1'b1;
                    for (int k = 0; k < n; k++) begin
                        if (w[k] != sig_bytes[i][n-1-k]) hit = 1'b0;
                    end
                    if (hit) found[i] = 1'b1;
                end
            end
            if (fill >= 1) begin
                if (hist[0] == BYTE_XCHG ||
                    (hist[0] == BYTE_MOV && (b & PIVOT_MASK) == PIVOT_REG_BASE)) begin
                    found[BIT_PIVOT] = 1'b1;
                end
            end
            need = (sled_len == 8'd0) ? 1 : int'(sled_len);
            if (b == BYTE_NOP) begin
                if (nop_run < 255) nop_run++;
                if (nop_run >= need) found[BIT_NOP] = 1'b1;
            end else begin
                nop_run = 0;
            end
            if (len_cnt < COUNT_MAX) len_cnt++;
            if (is_opcode_byte(b) && op_cnt < COUNT_MAX) op_cnt++;
            for (int k = 26; k > 0; k--) hist[k] = hist[k-1];
            hist[0] = b;
            if (fill < 27) fill++;
            bytes_seen++;
            if (!last) return;

            ok = (len_cnt >= {12'd0, min_scan});
            v = '0;
            if (ok) begin
                v.has_getproc      = found[BIT_GPA] | found[BIT_GPW];
                v.has_loader_walk  = found[BIT_LDR] & found[BIT_K32];
                v.has_stack_pivot  = found[BIT_PIVOT];
                v.has_nop_sled     = found[BIT_NOP];
                v.has_egg_hunter   = found[BIT_EGG];
                v.has_api_sequence = found[BIT_VA] & found[BIT_WPM] & found[BIT_CRT];
            end else begin
                short_buffers++;
            end
            v.byte_count   = len_cnt;
            v.opcode_count = op_cnt;
            num = {op_cnt, 16'h0000};
            quo = num / {16'd0, len_cnt};
            v.density_q16 = quo[16:0];
            flag_hits[0] += v.has_getproc;
            flag_hits[1] += v.has_loader_walk;
            flag_hits[2] += v.has_stack_pivot;
            flag_hits[3] += v.has_nop_sled;
            flag_hits[4] += v.has_egg_hunter;
            flag_hits[5] += v.has_api_sequence;
            expected_verdicts.push_back(v);
            buffers_seen++;
            clear_scan();
        endfunction

        function void compare_field(string name, logic [19:0] want, logic [19:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("MISMATCH verdict %0d field %s: expected 0x%0h, got 0x%0h",
                             buffers_seen - expected_verdicts.size(), name, want, got);
                end
            end
        endfunction

        // Compare one accepted verdict beat with the oldest prediction.
        function void check_verdict(logic [63:0] raw);
            verdict_t got;
            verdict_t want;
            got = raw;
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("MISMATCH verdict 0x%016h with none expected", raw);
                return;
            end
            want = expected_verdicts.pop_front();
            compare_field("has_getproc", want.has_getproc, got.has_getproc);
            compare_field("has_loader_walk", want.has_loader_walk, got.has_loader_walk);
            compare_field("has_stack_pivot", want.has_stack_pivot, got.has_stack_pivot);
            compare_field("has_nop_sled", want.has_nop_sled, got.has_nop_sled);
            compare_field("has_egg_hunter", want.has_egg_hunter, got.has_egg_hunter);
            compare_field("has_api_sequence", want.has_api_sequence, got.has_api_sequence);
            compare_field("byte_count", want.byte_count, got.byte_count);
            compare_field("opcode_count", want.opcode_count, got.opcode_count);
            compare_field("density_q16", want.density_q16, got.density_q16);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [0] has_getproc, [1] has_loader_walk, [2] has_stack_pivot, [3] has_nop_sled,
    // [4] has_egg_hunter, [5] has_api_sequence, [25:6] byte_count,
    // [45:26] opcode_count, [62:46] density_q16, [63] zero
    logic [63:0] m_axis_tdata;

    verdict_scoreboard sb = new();
    logic [7:0]        scan_buf[$];     // bytes of the buffer about to be streamed
    int                verdicts_seen;
    int                settings_used;

    byte_stream_shellcode_scanner DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Offer one byte beat after an idle gap and hold it until the block takes it.
    // tvalid is only dropped when a gap is wanted, so back-to-back beats keep it high.
    task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_byte(b, last);
    endtask

    // Stream scan_buf as one buffer; about a quarter of buffers go out with no gaps.
    task automatic send_buffer();
        bit steady;
        int gap;
        steady = ($urandom_range(0, 3) == 0);
        foreach (scan_buf[i]) begin
            gap = steady ? 0 : $urandom_range(0, 16);
            send_byte(scan_buf[i], i == scan_buf.size() - 1, gap);
        end
    endtask

    // Write both registers while the block is idle: drain all verdicts, let the
    // divider finish, then write the two registers back to back.
    task automatic set_regs(input logic [7:0] min_scan, input logic [7:0] sled_len);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_MIN_SCAN;
        i_cfg_wdata <= min_scan;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_SLED_LEN;
        i_cfg_wdata <= sled_len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.min_scan = min_scan;
        sb.sled_len = sled_len;
        settings_used++;
    endtask

    // Build a random buffer out of segments: whole search strings, loader and API
    // groups, NOP runs near the sled threshold, pivot pairs, strings with a byte
    // flipped or cut short, opcode runs and plain noise. The length lands on, just
    // under, or just over the scan threshold part of the time.
    task automatic build_buffer();
        int         target;
        int         n;
        int         idx;
        int         pos;
        int         rot;
        int         need;
        logic [7:0] seg[$];
        scan_buf.delete();
        case ($urandom_range(0, 7))
            0: target = int'(sb.min_scan);
            1: target = int'(sb.min_scan) - 1;
            2: target = $urandom_range(int'(sb.min_scan), int'(sb.min_scan) + 40);
            default: target = $urandom_range(1, 48);
        endcase
        if (target < 1) target = 1;
        while (scan_buf.size() < target) begin
            seg.delete();
            case ($urandom_range(0, 11))
                0: seg = sb.sig_bytes[$urandom_range(BIT_GPA, BIT_CRT)];
                1: begin
                    foreach (sb.sig_bytes[BIT_LDR][k]) seg.push_back(sb.sig_bytes[BIT_LDR][k]);
                    repeat ($urandom_range(0, 3)) seg.push_back(8'($urandom_range(0, 255)));
                    foreach (sb.sig_bytes[BIT_K32][k]) seg.push_back(sb.sig_bytes[BIT_K32][k]);
                end
                2: begin
                    // all three API names, in a rotated order with filler between
                    rot = $urandom_range(0, 2);
                    for (int j = 0; j < 3; j++) begin
                        idx = BIT_VA + (j + rot) % 3;
                        foreach (sb.sig_bytes[idx][k]) seg.push_back(sb.sig_bytes[idx][k]);
                        repeat ($urandom_range(0, 2)) seg.push_back(8'($urandom_range(0, 255)));
                    end
                end
                3: begin
                    need = (sb.sled_len == 8'd0) ? 1 : int'(sb.sled_len);
                    case ($urandom_range(0, 3))
                        0: n = need - 1;
                        1: n = need;
                        2: n = need + 1;
                        default: n = $urandom_range(1, 8);
                    endcase
                    if (n < 1) n = 1;
                    repeat (n) seg.push_back(BYTE_NOP);
                end
                4: begin
                    case ($urandom_range(0, 2))
                        0: seg = '{BYTE_XCHG, 8'($urandom_range(0, 255))};
                        1: seg = '{BYTE_MOV, PIVOT_REG_BASE | 8'($urandom_range(0, 7))};
                        default: seg = '{BYTE_MOV, 8'($urandom_range(0, 255))};
                    endcase
                end
                5: begin
                    // string with one byte flipped
                    seg = sb.sig_bytes[$urandom_range(BIT_GPA, BIT_CRT)];
                    pos = $urandom_range(0, seg.size() - 1);
                    seg[pos] = seg[pos] ^ 8'($urandom_range(1, 255));
                end
                6: begin
                    // string cut short
                    idx = $urandom_range(BIT_GPA, BIT_CRT);
                    n = $urandom_range(1, sb.sig_bytes[idx].size() - 1);
                    for (int k = 0; k < n; k++) seg.push_back(sb.sig_bytes[idx][k]);
                end
                7: repeat ($urandom_range(1, 6)) seg.push_back(sb.opcode_set[$urandom_range(0, 15)]);
                8: seg = sb.sig_bytes[$urandom_range(BIT_GPA, BIT_GPW)];
                default: repeat ($urandom_range(1, 8)) seg.push_back(8'($urandom_range(0, 255)));
            endcase
            foreach (seg[k]) scan_buf.push_back(seg[k]);
        end
        while (scan_buf.size() > target) void'(scan_buf.pop_back());
    endtask

    // Verdict sink: random stalls, some stretches with tready held high, and two
    // long hold-offs so that the output register and divider fill up and the
    // block has to stall its byte input.
    initial begin : verdict_sink
        int stall;
        m_axis_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (((verdicts_seen / 16) % 3) == 2) stall = 0;
            else stall = $urandom_range(0, 16);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            sb.check_verdict(m_axis_tdata);
            verdicts_seen++;
            if (verdicts_seen == 12 || verdicts_seen == 90) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Timeout: %0d verdicts still outstanding", sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int min_tab[NUM_TABLED];
        int sled_tab[NUM_TABLED];
        int rand_bytes;
        int phase_bytes;
        int phase;
        min_tab  = '{0, 1, 16, 255, 40, 0, 8, 2};
        sled_tab = '{1, 2, 16, 255, 0, 3, 1, 8};
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_MIN_SCAN;
        i_cfg_wdata   <= 8'h00;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, single-byte buffers below the threshold,
        // one of them all-opcode for full density.
        scan_buf = '{8'h00};
        send_buffer();
        scan_buf = '{8'hFF};
        send_buffer();

        // Threshold off and sled length zero (acts as one).
        set_regs(8'd0, 8'd0);
        scan_buf = '{BYTE_NOP};
        send_buffer();
        // exchange as the final byte has no partner: no pivot
        scan_buf = '{BYTE_XCHG};
        send_buffer();
        scan_buf = '{BYTE_XCHG, 8'h00};
        send_buffer();
        scan_buf = '{BYTE_MOV, 8'hE7};
        send_buffer();
        // 0xE8 is just past the register range
        scan_buf = '{BYTE_MOV, 8'hE8};
        send_buffer();
        scan_buf = '{8'h66, 8'h81, 8'h3C, 8'h33};
        send_buffer();

        // Random phases: a table of settings with the extremes, then random ones.
        rand_bytes = 0;
        phase = 0;
        while (rand_bytes < RANDOM_BYTES) begin
            if (phase < NUM_TABLED) begin
                set_regs(8'(min_tab[phase]), 8'(sled_tab[phase]));
            end else if ($urandom_range(0, 3) == 0) begin
                set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else begin
                set_regs(8'($urandom_range(0, 40)), 8'($urandom_range(1, 24)));
            end
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES && rand_bytes < RANDOM_BYTES) begin
                build_buffer();
                send_buffer();
                phase_bytes += scan_buf.size();
                rand_bytes  += scan_buf.size();
            end
            phase++;
        end

        // Drain: every verdict back, then let any stray beat show up.
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Scanned %0d bytes in %0d buffers over %0d register settings, %0d short",
                 sb.bytes_seen, sb.buffers_seen, settings_used, sb.short_buffers);
        $display("Flags raised: getproc %0d, loader %0d, pivot %0d, sled %0d, egg %0d, api %0d",
                 sb.flag_hits[0], sb.flag_hits[1], sb.flag_hits[2], sb.flag_hits[3],
                 sb.flag_hits[4], sb.flag_hits[5]);
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/bssc_pkg.sv
src/bssc_cell.sv
src/bssc_div.sv
src/byte_stream_shellcode_scanner.sv
src/bssc_chk.sv
dv/byte_stream_shellcode_scanner_tb.sv
